/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the block's checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off while reset is held.
`define CMND_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every rising edge, reset cycles included.
`define CMND_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/cmnd_pkg.sv */
// ----------------------------------------------------------------------------
// cmnd_pkg
// Types and codes shared by the constellation map and detect unit.
// ----------------------------------------------------------------------------
package cmnd_pkg;

    // Fixed field widths of the channels.
    localparam int SYM_W        = 8;
    localparam int FIELD_W      = 16;
    localparam int NUM_FIELDS   = 4;
    localparam int DIST_OUT_W   = 35;
    localparam int MAX_SAMPLE_W = 24;
    localparam int ACTION_W     = 2;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;
    localparam int BPS_W       = 4;
    localparam int CIU_W       = 3;
    localparam int MAX_BPS     = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_BITS_PER_SYMBOL = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COORDS_IN_USE   = 1'd1;

    localparam logic [BPS_W-1:0] BPS_RESET = 4'd4;
    localparam logic [CIU_W-1:0] CIU_RESET = 3'd4;

    // Item actions.
    localparam logic [ACTION_W-1:0] ACT_WRITE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_MAP    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DETECT = 2'd2;

    // Parameter defaults.
    localparam int MAX_POINTS_DEF   = 256;
    localparam int COORDS_DEF       = 4;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic map_read;
        logic scan_read;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
        logic pipe_busy;
        logic out_free;
    } status_t;

endpackage

/* src/cmnd_ram.sv */
// ----------------------------------------------------------------------------
// cmnd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cmnd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/cmnd_ctrl.sv */
// ----------------------------------------------------------------------------
// cmnd_ctrl
// Controller: sequences write, map and detect items over the datapath.
// ----------------------------------------------------------------------------
module cmnd_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [cmnd_pkg::ACTION_W-1:0]      s_action,
    input  cmnd_pkg::status_t                  status,
    output cmnd_pkg::cmd_t                     cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MAP_RD = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    case (s_action)
                        cmnd_pkg::ACT_MAP:    state_next = S_MAP_RD;
                        cmnd_pkg::ACT_DETECT: state_next = S_SCAN;
                        default:              state_next = S_IDLE;
                    endcase
                end
            end
            S_MAP_RD: begin
                cmd.map_read = 1'b1;
                state_next   = S_RESULT;
            end
            S_SCAN: begin
                cmd.scan_read = 1'b1;
                if (status.scan_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

/* src/cmnd_datapath.sv */
// ----------------------------------------------------------------------------
// cmnd_datapath
// Point table, configuration registers, distance pipeline and result register.
// ----------------------------------------------------------------------------
module cmnd_datapath #(
    parameter int MAX_POINTS   = cmnd_pkg::MAX_POINTS_DEF,
    parameter int COORDS       = cmnd_pkg::COORDS_DEF,
    parameter int SAMPLE_WIDTH = cmnd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [cmnd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [cmnd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic [cmnd_pkg::ACTION_W-1:0]         s_action,
    input  logic [cmnd_pkg::SYM_W-1:0]            s_symbol_in,
    input  logic signed [cmnd_pkg::FIELD_W-1:0]   s_value [cmnd_pkg::NUM_FIELDS],
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [cmnd_pkg::SYM_W-1:0]            m_symbol_out,
    output logic signed [cmnd_pkg::FIELD_W-1:0]   m_coord [cmnd_pkg::NUM_FIELDS],
    output logic [cmnd_pkg::DIST_OUT_W-1:0]       m_min_distance,
    input  cmnd_pkg::cmd_t                        cmd,
    output cmnd_pkg::status_t                     status
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int AW     = $clog2(MAX_POINTS);
    localparam int SYMW   = cmnd_pkg::SYM_W;
    localparam int FW     = cmnd_pkg::FIELD_W;
    localparam int MSW    = cmnd_pkg::MAX_SAMPLE_W;
    localparam int NF     = cmnd_pkg::NUM_FIELDS;
    localparam int SQ_W   = 2 * SW;
    localparam int DIST_W = 2 * SW + 2;
    localparam int OUT_W  = cmnd_pkg::DIST_OUT_W;
    localparam int WIDE_W = (DIST_W > OUT_W) ? DIST_W : OUT_W;
    localparam int WORD_W = COORDS * SW;
    // Reciprocal of the table depth; exact for every 8-bit index.
    localparam int RECIP_SH = 16;
    localparam int RECIP    = ((1 << RECIP_SH) + MAX_POINTS - 1) / MAX_POINTS;
    localparam int RP_W     = SYMW + RECIP_SH + 1;

    // ---------------- configuration ----------------
    logic [cmnd_pkg::BPS_W-1:0] bps_reg;
    logic [cmnd_pkg::CIU_W-1:0] ciu_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bps_reg <= cmnd_pkg::BPS_RESET;
            ciu_reg <= cmnd_pkg::CIU_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                cmnd_pkg::REG_BITS_PER_SYMBOL: bps_reg <= cfg_wdata;
                cmnd_pkg::REG_COORDS_IN_USE:   ciu_reg <= cfg_wdata[cmnd_pkg::CIU_W-1:0];
                default: ;
            endcase
        end
    end

    logic [cmnd_pkg::BPS_W-1:0] eff_bits;
    logic [cmnd_pkg::CIU_W-1:0] eff_coords;
    logic [SYMW:0]              mask_w;
    logic [SYMW:0]              last_pt;

    always_comb begin
        if (bps_reg == '0) begin
            eff_bits = cmnd_pkg::BPS_W'(1);
        end else if (bps_reg > cmnd_pkg::BPS_W'(cmnd_pkg::MAX_BPS)) begin
            eff_bits = cmnd_pkg::BPS_W'(cmnd_pkg::MAX_BPS);
        end else begin
            eff_bits = bps_reg;
        end
        if (ciu_reg == '0) begin
            eff_coords = cmnd_pkg::CIU_W'(1);
        end else if (ciu_reg > cmnd_pkg::CIU_W'(COORDS)) begin
            eff_coords = cmnd_pkg::CIU_W'(COORDS);
        end else begin
            eff_coords = ciu_reg;
        end
        mask_w = (SYMW + 1)'((SYMW + 1)'(1) << eff_bits) - (SYMW + 1)'(1);
        // The scan stops at the last point in use, capped by the table depth.
        if (mask_w >= (SYMW + 1)'(MAX_POINTS - 1)) begin
            last_pt = (SYMW + 1)'(MAX_POINTS - 1);
        end else begin
            last_pt = mask_w;
        end
    end

    // ---------------- item capture ----------------
    logic [MSW-1:0]       raw_ext [COORDS];
    logic signed [SW-1:0] samp_in [COORDS];
    logic signed [SW-1:0] samp_reg [COORDS];
    logic [WORD_W-1:0]    wr_word;
    logic [SYMW-1:0]      sym_reg;
    logic                 is_map_reg;

    always_comb begin
        for (int j = 0; j < COORDS; j++) begin
            raw_ext[j]           = MSW'($unsigned(s_value[j]));
            samp_in[j]           = raw_ext[j][SW-1:0];
            wr_word[j*SW +: SW]  = samp_in[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sym_reg    <= s_symbol_in;
            is_map_reg <= (s_action == cmnd_pkg::ACT_MAP);
            for (int j = 0; j < COORDS; j++) begin
                samp_reg[j] <= samp_in[j];
            end
        end
    end

    // ---------------- point table ----------------
    logic            ram_we;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic [SYMW-1:0] map_idx;
    logic [SYMW-1:0] masked_sym;
    logic [RP_W-1:0] recip_prod;
    logic [SYMW-1:0] map_quot;
    logic [2*SYMW:0] quot_mul;
    logic [AW-1:0]   scan_cnt_reg;

    // The masked index wraps at the table depth: quotient by reciprocal
    // multiplication, then the remainder by one subtraction.
    assign masked_sym = sym_reg & mask_w[SYMW-1:0];
    assign recip_prod = RP_W'(masked_sym) * RP_W'(RECIP);
    assign map_quot   = recip_prod[RECIP_SH +: SYMW];
    assign quot_mul   = (2 * SYMW + 1)'(map_quot) * (2 * SYMW + 1)'(MAX_POINTS);
    assign map_idx    = masked_sym - quot_mul[SYMW-1:0];

    assign ram_we  = cmd.capture && (s_action == cmnd_pkg::ACT_WRITE)
                     && ({1'b0, s_symbol_in} < (SYMW + 1)'(MAX_POINTS));
    assign ram_re    = cmd.map_read || cmd.scan_read;
    assign ram_raddr = cmd.map_read ? map_idx[AW-1:0] : scan_cnt_reg;

    cmnd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s_symbol_in[AW-1:0]),
        .wdata (wr_word),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            scan_cnt_reg <= '0;
        end else if (cmd.scan_read) begin
            scan_cnt_reg <= scan_cnt_reg + AW'(1);
        end
    end

    // ---------------- distance pipeline ----------------
    // Stages: table read, difference, square, sum, then the running minimum.
    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic [AW-1:0]        idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic signed [SW:0]   diff_reg [COORDS];
    logic signed [SW:0]   diff_next [COORDS];
    logic signed [2*SW+1:0] prod [COORDS];
    logic [SQ_W-1:0]      sq_reg [COORDS];
    logic [DIST_W-1:0]    sum_next;
    logic [DIST_W-1:0]    sum_reg;
    logic [DIST_W-1:0]    best_reg;
    logic [AW-1:0]        best_idx_reg;
    logic                 have_reg;

    always_comb begin
        sum_next = '0;
        for (int j = 0; j < COORDS; j++) begin
            if (cmnd_pkg::CIU_W'(j) < eff_coords) begin
                diff_next[j] = (SW + 1)'(samp_reg[j])
                               - (SW + 1)'($signed(ram_rdata[j*SW +: SW]));
            end else begin
                diff_next[j] = '0;
            end
            prod[j]  = diff_reg[j] * diff_reg[j];
            sum_next = sum_next + DIST_W'(sq_reg[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            have_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.scan_read;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (cmd.capture) begin
                have_reg <= 1'b0;
            end else if (v4_reg) begin
                have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx1_reg <= scan_cnt_reg;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        idx4_reg <= idx3_reg;
        for (int j = 0; j < COORDS; j++) begin
            diff_reg[j] <= diff_next[j];
            sq_reg[j]   <= prod[j][SQ_W-1:0];
        end
        sum_reg <= sum_next;
        // Strict less-than keeps the lowest index on a tie.
        if (v4_reg && (!have_reg || sum_reg < best_reg)) begin
            best_reg     <= sum_reg;
            best_idx_reg <= idx4_reg;
        end
    end

    // ---------------- result register ----------------
    logic signed [FW-1:0] map_coord [NF];
    logic [WIDE_W-1:0]    best_wide;
    logic [OUT_W-1:0]     best_sat;

    for (genvar k = 0; k < NF; k++) begin : g_map
        if (k < COORDS) begin : g_used
            logic signed [MSW-1:0] ext_w;
            assign ext_w        = MSW'($signed(ram_rdata[k*SW +: SW]));
            assign map_coord[k] = (cmnd_pkg::CIU_W'(k) < eff_coords) ? ext_w[FW-1:0] : '0;
        end else begin : g_unused
            assign map_coord[k] = '0;
        end
    end

    assign best_wide = WIDE_W'(best_reg);
    assign best_sat  = (best_wide > WIDE_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}}
                                                             : best_wide[OUT_W-1:0];

    logic                 m_valid_reg;
    logic [SYMW-1:0]      m_sym_reg;
    logic signed [FW-1:0] m_coord_reg [NF];
    logic [OUT_W-1:0]     m_dist_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (is_map_reg) begin
                m_sym_reg  <= map_idx;
                m_dist_reg <= '0;
                for (int k = 0; k < NF; k++) begin
                    m_coord_reg[k] <= map_coord[k];
                end
            end else begin
                m_sym_reg  <= SYMW'(best_idx_reg);
                m_dist_reg <= best_sat;
                for (int k = 0; k < NF; k++) begin
                    m_coord_reg[k] <= '0;
                end
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_symbol_out   = m_sym_reg;
    assign m_coord        = m_coord_reg;
    assign m_min_distance = m_dist_reg;

    assign status.scan_last = (scan_cnt_reg == last_pt[AW-1:0]);
    assign status.pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;
    assign status.out_free  = !m_valid_reg || m_ready;

endmodule

/* src/constellation_map_and_nearest_detect_unit.sv */
// ----------------------------------------------------------------------------
// constellation_map_and_nearest_detect_unit
// Constellation point table with a symbol mapper and a nearest-point detector.
//
// The input channel (s_*) takes one item per beat: action 0 stores a point at
// s_symbol_in, action 1 maps a symbol index to its point, action 2 searches
// the points in use for the smallest squared distance to s_value_0..3.
// Action 3 is dropped. The result channel (m_*) carries one beat per map or
// detect item; writes give none. Configuration is written through cfg_we,
// cfg_index and cfg_wdata; the user must write it only while no item is in
// flight, as the block itself does not enforce this. A write leaves the input
// side open for the next item. A map reads the table in S_MAP_RD, loads the
// result register in S_RESULT and is ready for the next item in the cycle after.
// A detect reads one table entry per cycle through the single RAM read port and
// drains a four-stage pipeline, then loads its result in S_RESULT.
// The result register lets the next item be accepted while a result waits;
// a finished result stalls in the controller until m_ready frees the register.
// Reset restores bits_per_symbol = 4 and coords_in_use = 4 and empties the
// result register. The point table keeps no reset and must be written before
// it is read.
// ----------------------------------------------------------------------------
module constellation_map_and_nearest_detect_unit #(
    parameter int MAX_POINTS   = cmnd_pkg::MAX_POINTS_DEF,
    parameter int COORDS       = cmnd_pkg::COORDS_DEF,
    parameter int SAMPLE_WIDTH = cmnd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [cmnd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [cmnd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [cmnd_pkg::ACTION_W-1:0]         s_action,
    input  logic [cmnd_pkg::SYM_W-1:0]            s_symbol_in,
    input  logic signed [cmnd_pkg::FIELD_W-1:0]   s_value_0,
    input  logic signed [cmnd_pkg::FIELD_W-1:0]   s_value_1,
    input  logic signed [cmnd_pkg::FIELD_W-1:0]   s_value_2,
    input  logic signed [cmnd_pkg::FIELD_W-1:0]   s_value_3,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [cmnd_pkg::SYM_W-1:0]            m_symbol_out,
    output logic signed [cmnd_pkg::FIELD_W-1:0]   m_coord_0,
    output logic signed [cmnd_pkg::FIELD_W-1:0]   m_coord_1,
    output logic signed [cmnd_pkg::FIELD_W-1:0]   m_coord_2,
    output logic signed [cmnd_pkg::FIELD_W-1:0]   m_coord_3,
    output logic [cmnd_pkg::DIST_OUT_W-1:0]       m_min_distance
);

    cmnd_pkg::cmd_t    cmd;
    cmnd_pkg::status_t status;

    logic signed [cmnd_pkg::FIELD_W-1:0] values [cmnd_pkg::NUM_FIELDS];
    logic signed [cmnd_pkg::FIELD_W-1:0] coords [cmnd_pkg::NUM_FIELDS];

    assign values[0] = s_value_0;
    assign values[1] = s_value_1;
    assign values[2] = s_value_2;
    assign values[3] = s_value_3;

    assign m_coord_0 = coords[0];
    assign m_coord_1 = coords[1];
    assign m_coord_2 = coords[2];
    assign m_coord_3 = coords[3];

    cmnd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .status   (status),
        .cmd      (cmd)
    );

    cmnd_datapath #(
        .MAX_POINTS   (MAX_POINTS),
        .COORDS       (COORDS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_action       (s_action),
        .s_symbol_in    (s_symbol_in),
        .s_value        (values),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_symbol_out   (m_symbol_out),
        .m_coord        (coords),
        .m_min_distance (m_min_distance),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

/* src/cmnd_checker.sv */
// ----------------------------------------------------------------------------
// cmnd_checker
// Port-level assertions for the constellation map and detect unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cmnd_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic [cmnd_pkg::ACTION_W-1:0]         s_action,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic [cmnd_pkg::SYM_W-1:0]            m_symbol_out,
    input logic signed [cmnd_pkg::FIELD_W-1:0]   m_coord_0,
    input logic signed [cmnd_pkg::FIELD_W-1:0]   m_coord_1,
    input logic signed [cmnd_pkg::FIELD_W-1:0]   m_coord_2,
    input logic signed [cmnd_pkg::FIELD_W-1:0]   m_coord_3,
    input logic [cmnd_pkg::DIST_OUT_W-1:0]       m_min_distance
);

    // A result beat waiting on the receiver is not withdrawn.
    `CMND_ASSERT(a_m_valid_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid, "m_valid dropped before acceptance")

    // A stalled result beat keeps its payload.
    `CMND_ASSERT(a_m_payload_hold, aclk, aresetn, m_valid && !m_ready |=> $stable(m_symbol_out) && $stable(m_min_distance) && $stable(m_coord_0) && $stable(m_coord_1) && $stable(m_coord_2) && $stable(m_coord_3), "stalled result changed")

    // Reset leaves the result side empty and the input side open.
    `CMND_ASSERT_ALWAYS(a_reset_state, aclk, !aresetn |=> !m_valid && s_ready, "bad state after reset")

    // Only a map result carries coordinates, and a map result has no distance.
    `CMND_ASSERT(a_map_no_dist, aclk, aresetn, m_valid && (m_coord_0 != 0 || m_coord_1 != 0 || m_coord_2 != 0 || m_coord_3 != 0) |-> m_min_distance == 0, "coordinates and distance both set")

    // A map or detect item keeps the input side closed while the table is read.
    `CMND_ASSERT(a_busy_after_lookup, aclk, aresetn, s_valid && s_ready && (s_action == cmnd_pkg::ACT_MAP || s_action == cmnd_pkg::ACT_DETECT) |=> !s_ready, "input accepted during a lookup")

endmodule

bind constellation_map_and_nearest_detect_unit cmnd_checker u_cmnd_checker (.*);
